>>> src/mss_pkg.sv
// shared types, codes and the segment decode table for the seven-segment scanner
package mss_pkg;

    localparam int DEF_MAX_DIGITS  = 8;
    localparam int DEF_DIGIT_COUNT = 4;

    localparam logic [7:0] POINT_MASK = 8'h80;

    localparam logic [2:0] FUNC_WRITE  = 3'd0;
    localparam logic [2:0] FUNC_SCAN   = 3'd1;
    localparam logic [2:0] FUNC_TOGGLE = 3'd2;
    localparam logic [2:0] FUNC_SET    = 3'd3;
    localparam logic [2:0] FUNC_CLEAR  = 3'd4;

    localparam logic [1:0] REG_DIGIT_COUNT  = 2'd0;
    localparam logic [1:0] REG_FLASH_FIRST  = 2'd1;
    localparam logic [1:0] REG_FLASH_LAST   = 2'd2;
    localparam logic [1:0] REG_FLASH_PERIOD = 2'd3;

    typedef struct packed {
        logic [2:0] func;
        logic [2:0] position;
        logic [3:0] bcd_value;
    } req_t;

    typedef struct packed {
        logic       drive_valid;
        logic [7:0] segments;
        logic [2:0] digit_select;
        logic       dot_state;
    } rsp_t;

    // segments a..g, bit 0 is a; values above nine are blank
    function automatic logic [6:0] seg_image(input logic [3:0] value);
        logic [6:0] img;
        case (value)
            4'd0:    img = 7'h3F;
            4'd1:    img = 7'h06;
            4'd2:    img = 7'h5B;
            4'd3:    img = 7'h4F;
            4'd4:    img = 7'h66;
            4'd5:    img = 7'h6D;
            4'd6:    img = 7'h7D;
            4'd7:    img = 7'h07;
            4'd8:    img = 7'h7F;
            4'd9:    img = 7'h6F;
            default: img = 7'h00;
        endcase
        return img;
    endfunction

endpackage

>>> src/multiplexed_seven_segment_scanner_top.sv
// top level of the multiplexed seven-segment scanner: request sequencing and result register
//
//  channel   direction   handshake               payload
//  req       in          req_valid / req_ready   req_data  (mss_pkg::req_t)
//  rsp       out         rsp_valid / rsp_ready   rsp_data  (mss_pkg::rsp_t)
//  cfg       in          cfg_we                  cfg_index, cfg_data
//
// one request per cycle sustained while results are taken; each result is registered by the modify stage
// the read stage reads the digit memory and moves the scan state, the modify stage writes the byte back
// and loads the result register; same-entry back-to-back requests forward inside the memory
// reset clears the digit valid bits, so every digit reads as zero with no clearing pass
// a full result register stalls the read-modify stage, which in turn drops req_ready
module multiplexed_seven_segment_scanner_top #(
    parameter int MAX_DIGITS = mss_pkg::DEF_MAX_DIGITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  mss_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output mss_pkg::rsp_t rsp_data,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data
);
    import mss_pkg::*;

    localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CW = $clog2(MAX_DIGITS + 1);

    logic          accept;
    logic          advance;
    logic          out_free;
    logic          tick;
    logic [CW-1:0] count;
    logic [AW-1:0] next_digit;
    logic          blank;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    logic          s1_valid_reg;
    logic [2:0]    s1_func_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [6:0]    s1_img_reg;
    logic          s1_ok_reg;
    logic          s1_blank_reg;
    logic [2:0]    s1_sel_reg;

    logic          rsp_valid_reg;
    rsp_t          rsp_data_reg;
    rsp_t          rsp_data_next;
    logic          we;
    logic [7:0]    wr_data;
    logic          req_ok;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign advance   = s1_valid_reg && out_free;
    assign req_ready = !s1_valid_reg || out_free;
    assign accept    = req_valid && req_ready;
    assign tick      = accept && (req_data.func == FUNC_SCAN);
    assign rd_addr   = (req_data.func == FUNC_SCAN) ? next_digit : AW'(req_data.position);

    always_comb
    begin
        case (req_data.func)
            FUNC_WRITE:  req_ok = 32'(req_data.position) < 32'(count);
            FUNC_TOGGLE,
            FUNC_SET,
            FUNC_CLEAR:  req_ok = 32'(req_data.position) < MAX_DIGITS;
            default:     req_ok = 1'b0;
        endcase
    end

    mss_scan #(
        .MAX_DIGITS (MAX_DIGITS),
        .AW         (AW),
        .CW         (CW)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .tick       (tick),
        .count      (count),
        .next_digit (next_digit),
        .blank      (blank)
    );

    mss_store #(
        .MAX_DIGITS (MAX_DIGITS),
        .AW         (AW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .we      (we),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg  <= req_data.func;
            s1_addr_reg  <= rd_addr;
            s1_img_reg   <= seg_image(req_data.bcd_value);
            s1_ok_reg    <= req_ok;
            s1_blank_reg <= blank;
            s1_sel_reg   <= 3'(next_digit);
        end
    end

    // modify the byte held in the read register and build the result
    always_comb
    begin
        rsp_data_next = '0;
        we            = 1'b0;
        wr_data       = rd_data;
        case (s1_func_reg)
            FUNC_WRITE:
            begin
                wr_data = (rd_data & POINT_MASK) | {1'b0, s1_img_reg};
                we      = s1_ok_reg;
            end
            FUNC_SCAN:
            begin
                rsp_data_next.drive_valid  = 1'b1;
                rsp_data_next.segments     = s1_blank_reg ? 8'h00 : rd_data;
                rsp_data_next.digit_select = s1_sel_reg;
            end
            FUNC_TOGGLE,
            FUNC_SET,
            FUNC_CLEAR:
            begin
                if (s1_func_reg == FUNC_TOGGLE)
                begin
                    wr_data = rd_data ^ POINT_MASK;
                end
                else if (s1_func_reg == FUNC_SET)
                begin
                    wr_data = rd_data | POINT_MASK;
                end
                else
                begin
                    wr_data = rd_data & ~POINT_MASK;
                end
                we                      = s1_ok_reg;
                rsp_data_next.dot_state = s1_ok_reg && ((wr_data & POINT_MASK) != 8'h00);
            end
            default: ;
        endcase
        we = we && advance;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    a_stall_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && rsp_valid && !rsp_ready) |-> !req_ready)
        else $error("request taken while the modify stage is stalled");

    a_scan_drives: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (s1_func_reg == FUNC_SCAN)) |=> (rsp_valid && rsp_data.drive_valid))
        else $error("scan request did not give a drive result");

    a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_data.drive_valid) |->
        ((rsp_data.segments == 8'h00) && (rsp_data.digit_select == 3'd0)))
        else $error("non-scan result carries display fields");

    a_no_write_on_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_func_reg == FUNC_SCAN)) |-> !we)
        else $error("scan request wrote the digit memory");

endmodule

>>> src/mss_store.sv
// digit segment memory: one write port, one registered read port, valid bits
module mss_store #(
    parameter int MAX_DIGITS = mss_pkg::DEF_MAX_DIGITS,
    parameter int AW         = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    input  logic          we,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data
);
    import mss_pkg::*;

    logic [7:0]            mem_reg [MAX_DIGITS];
    logic [MAX_DIGITS-1:0] valid_reg;
    logic [7:0]            rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // write-first: a read of the entry written at the same edge sees the new byte
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (we && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else if (valid_reg[rd_addr])
            begin
                rd_data_reg <= mem_reg[rd_addr];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/mss_scan.sv
// configuration registers, active digit and flash counter
module mss_scan #(
    parameter int MAX_DIGITS = mss_pkg::DEF_MAX_DIGITS,
    parameter int AW         = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1,
    parameter int CW         = $clog2(MAX_DIGITS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    input  logic          tick,
    output logic [CW-1:0] count,
    output logic [AW-1:0] next_digit,
    output logic          blank
);
    import mss_pkg::*;

    localparam int RST_COUNT = (DEF_DIGIT_COUNT > MAX_DIGITS) ? MAX_DIGITS : DEF_DIGIT_COUNT;

    logic [3:0]    digit_count_reg;
    logic [2:0]    flash_first_reg;
    logic [2:0]    flash_last_reg;
    logic [15:0]   flash_period_reg;
    logic [15:0]   flash_cnt_reg;
    logic [15:0]   flash_cnt_next;
    logic [AW-1:0] active_reg;
    logic [AW-1:0] active_next;

    logic [CW-1:0] sum;
    logic [CW-1:0] next;
    logic [16:0]   cnt_inc;
    logic [15:0]   cnt_wrap;
    logic          in_range;

    function automatic logic [CW-1:0] eff_count(input logic [3:0] value);
        logic [CW-1:0] result;
        if (value == 4'd0)
        begin
            result = CW'(1);
        end
        else if (32'(value) > MAX_DIGITS)
        begin
            result = CW'(MAX_DIGITS);
        end
        else
        begin
            result = CW'(value);
        end
        return result;
    endfunction

    assign count = eff_count(digit_count_reg);

    always_comb
    begin
        sum      = CW'(active_reg) + CW'(1);
        next     = (sum >= count) ? '0 : sum;
        cnt_inc  = {1'b0, flash_cnt_reg} + 17'd1;
        // counter stays below the period, so one compare gives the modulo
        cnt_wrap = (cnt_inc == {1'b0, flash_period_reg}) ? 16'd0 : cnt_inc[15:0];
        if ((flash_period_reg != 16'd0) && (next == '0))
        begin
            flash_cnt_next = cnt_wrap;
        end
        else
        begin
            flash_cnt_next = flash_cnt_reg;
        end
        in_range = (32'(next) >= 32'(flash_first_reg)) && (32'(next) <= 32'(flash_last_reg));
        blank    = (flash_period_reg != 16'd0) && in_range &&
                   (flash_cnt_next > (flash_period_reg >> 1));
        active_next = AW'(next);
    end

    assign next_digit = active_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg  <= 4'(DEF_DIGIT_COUNT);
            flash_first_reg  <= '0;
            flash_last_reg   <= '0;
            flash_period_reg <= '0;
            flash_cnt_reg    <= '0;
            active_reg       <= AW'(RST_COUNT - 1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DIGIT_COUNT:
                begin
                    digit_count_reg <= cfg_data[3:0];
                    active_reg      <= AW'(eff_count(cfg_data[3:0]) - CW'(1));
                end
                REG_FLASH_FIRST:  flash_first_reg <= cfg_data[2:0];
                REG_FLASH_LAST:   flash_last_reg  <= cfg_data[2:0];
                REG_FLASH_PERIOD:
                begin
                    flash_period_reg <= cfg_data;
                    flash_cnt_reg    <= '0;
                end
                default: ;
            endcase
        end
        else if (tick)
        begin
            active_reg    <= active_next;
            flash_cnt_reg <= flash_cnt_next;
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// self-checking bench for the seven-segment scanner: directed table, then randomized phases
module tb;
    import mss_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 85;
    localparam int LONG_HOLD      = 150;

    // a..g patterns, digit 9 leftmost down to digit 0 rightmost, bit 0 is segment a
    localparam logic [69:0] DIGIT_FONT = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                          7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

    localparam rsp_t NO_RESULT  = '0;
    localparam rsp_t DOT_ON     = {1'b0, 8'h00, 3'd0, 1'b1};
    localparam rsp_t FIRST_SCAN = {1'b1, 8'h00, 3'd0, 1'b0};

    typedef struct {
        req_t r;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    typedef struct {
        int unsigned count;
        int unsigned first;
        int unsigned last;
        int unsigned period;
    } display_cfg_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid;
    logic        req_ready;
    req_t        req_data;
    logic        rsp_valid;
    logic        rsp_ready;
    rsp_t        rsp_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // shadow of the display state
    logic [7:0]  digit_img [DEF_MAX_DIGITS];
    int unsigned scan_pos;
    int unsigned sweep_count;
    int unsigned cfg_count;
    int unsigned cfg_first;
    int unsigned cfg_last;
    int unsigned cfg_period;

    rsp_t        pending_frames [$];
    rsp_t        frame_head;
    dir_row_t    dir_rows [$];
    int          errors = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          stall_hold = 0;
    int          quiet_cycles;

    always #5 clk = ~clk;

    multiplexed_seven_segment_scanner_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic int unsigned live_digits();
        if (cfg_count == 0)
            return 1;
        if (cfg_count > DEF_MAX_DIGITS)
            return DEF_MAX_DIGITS;
        return cfg_count;
    endfunction

    function automatic rsp_t predict_display(input req_t r);
        rsp_t        o;
        int unsigned nxt;
        logic [7:0]  b;
        o = '0;
        case (r.func)
            FUNC_WRITE:
            begin
                if (r.position < live_digits())
                begin
                    b = (r.bcd_value < 10) ? {1'b0, DIGIT_FONT[r.bcd_value * 7 +: 7]} : 8'h00;
                    digit_img[r.position] = (digit_img[r.position] & POINT_MASK) | b;
                end
            end
            FUNC_SCAN:
            begin
                nxt = scan_pos + 1;
                if (nxt >= live_digits())
                    nxt = 0;
                scan_pos = nxt;
                b = digit_img[nxt];
                if (cfg_period != 0)
                begin
                    // sweep count moves on the wrap, ahead of the blank test
                    if (nxt == 0)
                        sweep_count = (sweep_count + 1) % cfg_period;
                    if (nxt >= cfg_first && nxt <= cfg_last && sweep_count > cfg_period / 2)
                        b = 8'h00;
                end
                o.drive_valid  = 1'b1;
                o.segments     = b;
                o.digit_select = nxt[2:0];
            end
            FUNC_TOGGLE, FUNC_SET, FUNC_CLEAR:
            begin
                // every 3-bit position is inside the store, even beyond the digit count
                b = digit_img[r.position];
                if (r.func == FUNC_TOGGLE)
                    b = b ^ POINT_MASK;
                else if (r.func == FUNC_SET)
                    b = b | POINT_MASK;
                else
                    b = b & ~POINT_MASK;
                digit_img[r.position] = b;
                o.dot_state = b[7];
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    function automatic dir_row_t mk_row(input logic [2:0] f, input int unsigned pos,
                                        input int unsigned val, input bit typed,
                                        input rsp_t want);
        dir_row_t d;
        d.r.func      = f;
        d.r.position  = 3'(pos);
        d.r.bcd_value = 4'(val);
        d.typed       = typed;
        d.want        = want;
        return d;
    endfunction

    function automatic req_t rand_request();
        req_t        r;
        int unsigned pick;
        pick = $urandom_range(99);
        r.position  = 3'($urandom_range(7));
        r.bcd_value = ($urandom_range(99) < 75) ? 4'($urandom_range(9))
                                                : 4'($urandom_range(15, 10));
        if (pick < 40)
            r.func = FUNC_SCAN;
        else if (pick < 70)
        begin
            r.func = FUNC_WRITE;
            // most writes land on digits that are scanned
            if ($urandom_range(99) < 80)
                r.position = 3'($urandom_range(live_digits() - 1));
        end
        else if (pick < 78)
            r.func = FUNC_TOGGLE;
        else if (pick < 86)
            r.func = FUNC_SET;
        else if (pick < 94)
            r.func = FUNC_CLEAR;
        else
            r.func = FUNC_CLEAR + 3'($urandom_range(3, 1));
        return r;
    endfunction

    function automatic display_cfg_t phase_settings(input int p);
        display_cfg_t s;
        case (p)
            0:       s = '{8, 0, 7, 3};
            1:       s = '{1, 0, 0, 1};
            2:       s = '{0, 0, 0, 3};
            3:       s = '{15, 2, 5, 4};
            4:       s = '{5, 5, 2, 2};
            5:       s = '{3, 1, 7, 65535};
            6:       s = '{8, 7, 7, 5};
            7:       s = '{9, 0, 7, 0};
            8:       s = '{6, 3, 3, 7};
            default: s = '{2, 0, 1, 6};
        endcase
        return s;
    endfunction

    task automatic send_req(input req_t r, input bit typed, input rsp_t want);
        rsp_t model;
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (!req_ready);
        model = predict_display(r);
        pending_frames.push_back(typed ? want : model);
    endtask

    task automatic sender_gap();
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain_frames();
        req_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_put(input logic [1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic load_settings(input display_cfg_t s);
        // narrow registers get random upper bits, only the low bits count
        cfg_put(REG_DIGIT_COUNT, {12'($urandom), 4'(s.count)});
        cfg_put(REG_FLASH_FIRST, {13'($urandom), 3'(s.first)});
        cfg_put(REG_FLASH_LAST, {13'($urandom), 3'(s.last)});
        cfg_put(REG_FLASH_PERIOD, 16'(s.period));
        cfg_we      <= 1'b0;
        cfg_count   = s.count;
        cfg_first   = s.first;
        cfg_last    = s.last;
        cfg_period  = s.period;
        scan_pos    = live_digits() - 1;
        sweep_count = 0;
    endtask

    // receiver side: random stalls plus an occasional long hold-off
    initial
    begin
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_hold > 0)
            begin
                rsp_ready <= 1'b0;
                stall_hold--;
            end
            else
                rsp_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_frames.size() == 0)
            begin
                $error("result with no request outstanding: %h", rsp_data);
                errors++;
            end
            else
            begin
                frame_head = pending_frames.pop_front();
                if (rsp_data.drive_valid !== frame_head.drive_valid)
                begin
                    $error("drive_valid: expected %0d, actual %0d",
                           frame_head.drive_valid, rsp_data.drive_valid);
                    errors++;
                end
                if (rsp_data.segments !== frame_head.segments)
                begin
                    $error("segments: expected %h, actual %h",
                           frame_head.segments, rsp_data.segments);
                    errors++;
                end
                if (rsp_data.digit_select !== frame_head.digit_select)
                begin
                    $error("digit_select: expected %0d, actual %0d",
                           frame_head.digit_select, rsp_data.digit_select);
                    errors++;
                end
                if (rsp_data.dot_state !== frame_head.dot_state)
                begin
                    $error("dot_state: expected %0d, actual %0d",
                           frame_head.dot_state, rsp_data.dot_state);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        display_cfg_t s;
        int           p;
        int           k;
        req_valid = 1'b0;
        req_data  = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        foreach (digit_img[i])
            digit_img[i] = 8'h00;
        cfg_count   = DEF_DIGIT_COUNT;
        cfg_first   = 0;
        cfg_last    = 0;
        cfg_period  = 0;
        sweep_count = 0;
        scan_pos    = live_digits() - 1;

        dir_rows.push_back(mk_row(FUNC_SCAN, 0, 0, 1, FIRST_SCAN));
        dir_rows.push_back(mk_row(FUNC_WRITE, 0, 8, 1, NO_RESULT));
        dir_rows.push_back(mk_row(FUNC_WRITE, 1, 15, 1, NO_RESULT));
        dir_rows.push_back(mk_row(FUNC_WRITE, 2, 0, 1, NO_RESULT));
        dir_rows.push_back(mk_row(FUNC_WRITE, 3, 9, 1, NO_RESULT));
        // writes at or past the digit count are dropped
        dir_rows.push_back(mk_row(FUNC_WRITE, 7, 5, 1, NO_RESULT));
        dir_rows.push_back(mk_row(FUNC_WRITE, 4, 10, 1, NO_RESULT));
        dir_rows.push_back(mk_row(FUNC_SET, 0, 0, 1, DOT_ON));
        dir_rows.push_back(mk_row(FUNC_TOGGLE, 0, 3, 1, NO_RESULT));
        // dot requests still act past the digit count
        dir_rows.push_back(mk_row(FUNC_TOGGLE, 7, 0, 1, DOT_ON));
        dir_rows.push_back(mk_row(FUNC_CLEAR, 7, 0, 1, NO_RESULT));
        dir_rows.push_back(mk_row(FUNC_SET, 3, 0, 1, DOT_ON));
        dir_rows.push_back(mk_row(FUNC_WRITE, 3, 1, 1, NO_RESULT));
        dir_rows.push_back(mk_row(FUNC_CLEAR + 3'd1, 7, 15, 1, NO_RESULT));
        dir_rows.push_back(mk_row(FUNC_CLEAR + 3'd2, 5, 10, 1, NO_RESULT));
        dir_rows.push_back(mk_row(FUNC_CLEAR + 3'd3, 2, 3, 1, NO_RESULT));
        for (k = 0; k < 5; k++)
            dir_rows.push_back(mk_row(FUNC_SCAN, 6, 12, 0, NO_RESULT));
        dir_rows.push_back(mk_row(FUNC_WRITE, 1, 10, 1, NO_RESULT));
        dir_rows.push_back(mk_row(FUNC_CLEAR, 3, 0, 1, NO_RESULT));
        dir_rows.push_back(mk_row(FUNC_SCAN, 0, 0, 0, NO_RESULT));
        dir_rows.push_back(mk_row(FUNC_SCAN, 0, 0, 0, NO_RESULT));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < dir_rows.size(); k++)
            send_req(dir_rows[k].r, dir_rows[k].typed, dir_rows[k].want);

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_frames();
            repeat (SETTLE_CYCLES) @(posedge clk);
            s = phase_settings(p);
            load_settings(s);
            case (p % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 73;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 73;
                end
                default:
                begin
                    idle_pct  = 23;
                    stall_pct = 23;
                end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                // receiver holds off while requests keep coming, so the block backs up
                if (p == 0 && k == 20)
                    stall_hold = LONG_HOLD;
                if (p == 5 && k == PHASE_ITEMS / 2)
                    drain_frames();
                send_req(rand_request(), 1'b0, NO_RESULT);
                sender_gap();
            end
        end

        drain_frames();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
